[design/signed_restoring_divider_macros.svh]
// assertion macros for the signed restoring divider
`ifndef SIGNED_RESTORING_DIVIDER_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_MACROS_SVH

`ifndef SYNTHESIS

`define SRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("signed_restoring_divider: assertion failed");

`define SRD_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("signed_restoring_divider: forbidden condition seen");

`else

`define SRD_ASSERT(lbl, prop)

`define SRD_NEVER(lbl, expr)

`endif

`endif

[design/srd_pkg.sv]
// shared widths and types for the signed restoring divider
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    localparam int WIDTH = 32;
    localparam int DATA_BITS = 2 * WIDTH;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

    // one division in flight: partial remainder, dividend/quotient shift word, divisor magnitude, sign flags
    typedef struct packed {
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] dvs;
        logic             q_neg;
        logic             r_neg;
    } t_lane;

endpackage

`default_nettype wire

[design/signed_restoring_divider.sv]
// top level of the pipelined signed restoring divider
`timescale 1ns / 1ps
`default_nettype none

`include "signed_restoring_divider_macros.svh"

// Signed 32-bit divider, fully pipelined: one operand pair can be accepted every
// cycle while the skid word is free. Operands pass through a register for the
// operand magnitudes, a chain of 32 shift-subtract stages with one quotient bit
// per stage, and the sign fix into the output register.
// The quotient truncates toward zero and the remainder carries the sign of the
// dividend; division by zero returns quotient 1 and the dividend as remainder,
// and the most negative value divided by -1 wraps to itself. A one-word skid
// register behind the output lets the whole pipeline stall on back-pressure
// without losing or repeating a word.
module signed_restoring_divider (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // dividend [31:0], divisor [63:32]
    input  wire logic [srd_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // quotient [31:0], remainder [63:32]
    output logic [srd_pkg::TDATA_BITS-1:0]       m_axis_tdata
);
    import srd_pkg::*;

    logic             pipe_en;
    logic             in_take;
    logic             out_take;

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic             a_neg;
    logic             b_neg;
    logic             a_pos;
    logic             b_pos;
    t_lane            n_head;

    logic             stage_valid [0:WIDTH];
    t_lane            stage_lane  [0:WIDTH];

    logic             r_head_valid;
    t_lane            r_head;

    logic [WIDTH-1:0] fin_q;
    logic [WIDTH-1:0] fin_r;
    logic             tail_valid;

    logic             r_o_valid;
    logic [2*WIDTH-1:0] r_o_data;
    logic             r_skid_valid;
    logic [2*WIDTH-1:0] r_skid_data;

    // the pipeline moves whenever the skid word is free
    assign pipe_en       = !r_skid_valid;
    assign s_axis_tready = pipe_en;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_o_valid && m_axis_tready;

    always_comb begin
        a     = s_axis_tdata[WIDTH-1:0];
        b     = s_axis_tdata[2*WIDTH-1:WIDTH];
        a_neg = a[WIDTH-1];
        b_neg = b[WIDTH-1];
        a_pos = !a_neg && (|a);
        b_pos = !b_neg && (|b);
        n_head.rem   = '0;
        n_head.quo   = a_neg ? (-a) : a;
        n_head.dvs   = b_neg ? (-b) : b;
        n_head.q_neg = !((a_pos && b_pos) || (a_neg && b_neg));
        n_head.r_neg = !a_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
        end else if (pipe_en) begin
            r_head_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_head <= n_head;
        end
    end

    assign stage_valid[0] = r_head_valid;
    assign stage_lane[0]  = r_head;

    // one quotient bit per stage, top bit first
    for (genvar g = 0; g < WIDTH; g++) begin : g_step
        srd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (stage_valid[g]),
            .i_lane  (stage_lane[g]),
            .o_valid (stage_valid[g+1]),
            .o_lane  (stage_lane[g+1])
        );
    end

    always_comb begin
        fin_q = stage_lane[WIDTH].q_neg ? (-stage_lane[WIDTH].quo)
                                        : stage_lane[WIDTH].quo;
        fin_r = stage_lane[WIDTH].r_neg ? (-stage_lane[WIDTH].rem)
                                        : stage_lane[WIDTH].rem;
        tail_valid = stage_valid[WIDTH] && pipe_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_o_valid || out_take) begin
                r_o_valid    <= r_skid_valid || tail_valid;
                r_skid_valid <= 1'b0;
            end else if (tail_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || out_take) begin
            r_o_data <= r_skid_valid ? r_skid_data : {fin_r, fin_q};
        end
        if (pipe_en) begin
            r_skid_data <= {fin_r, fin_q};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = TDATA_BITS'(r_o_data);

    `SRD_NEVER(a_skid_without_out, r_skid_valid && !r_o_valid)
    `SRD_ASSERT(a_skid_fills_on_stall,
        $rose(r_skid_valid) |-> $past(r_o_valid && !m_axis_tready))
    `SRD_ASSERT(a_entry_reaches_head, in_take |=> r_head_valid)

endmodule

`default_nettype wire

[design/srd_step.sv]
// one restoring shift-subtract step of the divider pipeline
`timescale 1ns / 1ps
`default_nettype none

module srd_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire srd_pkg::t_lane i_lane,
    output logic               o_valid,
    output srd_pkg::t_lane     o_lane
);
    import srd_pkg::*;

    logic             r_valid;
    t_lane            r_lane;
    t_lane            n_lane;
    logic [WIDTH-1:0] shifted;
    logic [WIDTH:0]   trial;
    logic             fits;

    always_comb begin
        // rem stays below a nonzero divisor magnitude, so the shift cannot overflow
        shifted = {i_lane.rem[WIDTH-2:0], i_lane.quo[WIDTH-1]};
        trial   = {1'b0, shifted} - {1'b0, i_lane.dvs};
        fits    = !trial[WIDTH];
        n_lane  = i_lane;
        n_lane.rem = fits ? trial[WIDTH-1:0] : shifted;
        n_lane.quo = {i_lane.quo[WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

[dv/signed_restoring_divider_test.sv]
// self-checking stream testbench for the pipelined signed restoring divider
`timescale 1ns / 1ps

module signed_restoring_divider_test;

    import srd_pkg::*;

    localparam int W = srd_pkg::WIDTH;
    localparam int TD = srd_pkg::TDATA_BITS;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PAIRS = 1000;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
    } quo_rem_t;

    class division_board;
        quo_rem_t expected_results[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // restoring shift-subtract on the magnitudes, then sign fix-up
        function quo_rem_t divide_signed(logic [W-1:0] a, logic [W-1:0] b);
            logic a_neg, b_neg, a_pos, b_pos;
            logic [W-1:0] am, bm, q, r;
            quo_rem_t res;
            a_neg = a[W-1];
            b_neg = b[W-1];
            a_pos = !a_neg && (a != '0);
            b_pos = !b_neg && (b != '0);
            am = a_neg ? -a : a;
            bm = b_neg ? -b : b;
            q = '0;
            r = '0;
            for (int i = W - 1; i >= 0; i--) begin
                r = {r[W-2:0], am[i]};
                if (r >= bm) begin
                    r = r - bm;
                    q[i] = 1'b1;
                end
            end
            if (!((a_pos && b_pos) || (a_neg && b_neg)))
                q = -q;
            if (!a_pos)
                r = -r;
            res.quotient = q;
            res.remainder = r;
            return res;
        endfunction

        function void note_operands(logic [W-1:0] a, logic [W-1:0] b);
            expected_results.push_back(divide_signed(a, b));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [TD-1:0] word);
            quo_rem_t want;
            logic [W-1:0] got_q, got_r;
            got_q = word[W-1:0];
            got_r = word[2*W-1:W];
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected word q=%h r=%h", got_q, got_r));
            end else begin
                want = expected_results.pop_front();
                if (got_q !== want.quotient)
                    report($sformatf("quotient %h, expected %h", got_q, want.quotient));
                if (got_r !== want.remainder)
                    report($sformatf("remainder %h, expected %h", got_r, want.remainder));
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // dividend [31:0], divisor [63:32]
    logic [TD-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // quotient [31:0], remainder [63:32]
    logic [TD-1:0] m_axis_tdata;

    division_board board;
    logic steady;

    signed_restoring_divider DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        steady = 1'b0;
        board = new();
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, none during the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_operands(s_axis_tdata[W-1:0], s_axis_tdata[2*W-1:W]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // ends the run when neither side has moved a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    task send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 15)
            gap = $urandom_range(1, 3);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= TD'({b, a});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task wait_for_drain();
        while (board.pending() > 0)
            @(posedge i_clk);
    endtask

    function logic [W-1:0] pick_extreme();
        case ($urandom_range(5))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return W'(1);
            4: return MINUS_ONE;
            default: return MOST_NEG + W'(1);
        endcase
    endfunction

    function logic [W-1:0] small_signed(int span);
        return W'($urandom_range(2 * span) - span);
    endfunction

    initial begin : stimulus
        logic [W-1:0] a, b;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: zero divisor, most negative operand, signs, zero dividend
        send_pair(W'(7), '0);
        send_pair(-W'(7), '0);
        send_pair('0, '0);
        send_pair(MOST_NEG, '0);
        send_pair(MOST_POS, '0);
        send_pair('0, W'(5));
        send_pair('0, -W'(3));
        send_pair(MOST_NEG, MINUS_ONE);
        send_pair(MOST_NEG, W'(1));
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MINUS_ONE, MOST_NEG);
        send_pair(MOST_POS, MINUS_ONE);
        send_pair(MOST_POS, MOST_POS);
        send_pair(W'(1), MOST_POS);
        send_pair(W'(7), W'(2));
        send_pair(-W'(7), W'(2));
        send_pair(W'(7), -W'(2));
        send_pair(-W'(7), -W'(2));
        send_pair(W'(1), MINUS_ONE);
        send_pair(MOST_NEG, W'(2));

        // hold off until the pipeline has emptied
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_for_drain();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            steady = (n >= 400 && n < 600);
            case ($urandom_range(99)) inside
                [0:39]: begin
                    a = $urandom();
                    b = $urandom();
                end
                [40:59]: begin
                    a = small_signed(300);
                    b = small_signed(40);
                end
                [60:74]: begin
                    a = $urandom();
                    b = small_signed(1000);
                end
                [75:82]: begin
                    a = $urandom();
                    b = '0;
                end
                [83:92]: begin
                    a = ($urandom_range(1)) ? pick_extreme() : $urandom();
                    b = ($urandom_range(1)) ? pick_extreme() : small_signed(8);
                end
                default: begin
                    // exact multiple, remainder should come out zero
                    b = small_signed(5000);
                    a = b * small_signed(5000);
                end
            endcase
            send_pair(a, b);
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/srd_pkg.sv
design/srd_step.sv
design/signed_restoring_divider.sv
dv/signed_restoring_divider_test.sv
